FILE: src/eapg_pkg.sv
package eapg_pkg;

    localparam int CORDIC_STAGES = 18;
    localparam int ATAN_LEN      = 24;
    localparam int DIV_Q_BITS    = 24;
    localparam int DEN_W         = 14;
    localparam int NUM_W         = DEN_W + DIV_Q_BITS;
    localparam int TRIG_W        = 33;
    localparam int Z_W           = 25;

    localparam logic [15:0] TURN_UNITS    = 16'd46080;
    localparam logic [23:0] FINE_TURN     = 24'd11796480;
    localparam logic [23:0] FINE_QUARTER  = 24'd2949120;
    localparam logic [14:0] RECIP_45      = 15'd23302;
    localparam logic [5:0]  STEP_DIV      = 6'd45;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [19:0] COORD_MAX = 20'sd65535;

    localparam logic [20:0] ATAN_FINE [ATAN_LEN] = '{
        21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
        21'd29333, 21'd14667, 21'd7334, 21'd3667, 21'd1833, 21'd917,
        21'd458, 21'd229, 21'd115, 21'd57, 21'd29, 21'd14,
        21'd7, 21'd4, 21'd2, 21'd1, 21'd0, 21'd0
    };

    typedef struct packed {
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] st;
        logic [14:0] steps;
        logic        valid;
        logic        last;
        logic [1:0]  quad;
    } meta_t;

endpackage

FILE: src/eapg_steps.sv
module eapg_steps
    import eapg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pipe_en,
    input  logic              in_valid,
    input  logic [15:0]       rx,
    input  logic [15:0]       ry,
    input  logic [15:0]       arc_start,
    input  logic [15:0]       arc_end,
    input  logic [13:0]       idx,
    output logic              out_valid,
    output logic [NUM_W-1:0]  num,
    output logic [DEN_W-1:0]  den,
    output meta_t             meta
);

    logic [4:0]  v_reg;

    logic [15:0] rx1_reg, ry1_reg, st1_reg, en1_reg;
    logic [13:0] idx1_reg;
    logic [12:0] m1_reg;

    logic [15:0] rx2_reg, ry2_reg, st2_reg, span2_reg;
    logic [13:0] idx2_reg;
    logic [12:0] m2_reg;

    logic [15:0] rx3_reg, ry3_reg, st3_reg;
    logic [13:0] idx3_reg;
    logic [27:0] prod3_reg;
    logic [29:0] ip3_reg;

    logic [15:0] rx4_reg, ry4_reg, st4_reg;
    logic [13:0] idx4_reg;
    logic [29:0] ip4_reg;
    logic [19:0] x4_reg;
    logic [14:0] q04_reg;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    meta_t            meta_reg;
    meta_t            meta_next;

    logic [15:0] st_red, en_red, span;
    logic [12:0] mx, my;
    logic [16:0] rx_up, ry_up;
    logic [34:0] recip_prod;
    logic [20:0] chk;
    logic [14:0] steps;
    logic        valid;

    assign st_red = (arc_start >= TURN_UNITS) ? arc_start - TURN_UNITS : arc_start;
    assign en_red = (arc_end >= TURN_UNITS) ? arc_end - TURN_UNITS : arc_end;
    assign rx_up  = {1'b0, rx} + 17'd15;
    assign ry_up  = {1'b0, ry} + 17'd15;
    assign mx     = rx_up[16:4];
    assign my     = ry_up[16:4];

    assign span = (en1_reg >= st1_reg) ? en1_reg - st1_reg
                                       : en1_reg - st1_reg + TURN_UNITS;

    assign recip_prod = {15'd0, prod3_reg[27:8]} * {20'd0, RECIP_45};

    assign chk   = {6'd0, q04_reg} * {15'd0, STEP_DIV};
    assign steps = (chk > {1'b0, x4_reg}) ? q04_reg - 15'd1 : q04_reg;
    assign valid = {1'b0, idx4_reg} < steps;

    always_comb begin
        meta_next.rx    = rx4_reg;
        meta_next.ry    = ry4_reg;
        meta_next.st    = st4_reg;
        meta_next.steps = steps;
        meta_next.valid = valid;
        meta_next.last  = valid && (({1'b0, idx4_reg} + 15'd1) == steps);
        meta_next.quad  = 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
        if (pipe_en) begin
            rx1_reg  <= rx;
            ry1_reg  <= ry;
            st1_reg  <= st_red;
            en1_reg  <= en_red;
            idx1_reg <= idx;
            m1_reg   <= (mx > my) ? mx : my;

            rx2_reg   <= rx1_reg;
            ry2_reg   <= ry1_reg;
            st2_reg   <= st1_reg;
            idx2_reg  <= idx1_reg;
            m2_reg    <= m1_reg;
            span2_reg <= span;

            rx3_reg   <= rx2_reg;
            ry3_reg   <= ry2_reg;
            st3_reg   <= st2_reg;
            idx3_reg  <= idx2_reg;
            prod3_reg <= 28'({15'd0, m2_reg} * {12'd0, span2_reg});
            ip3_reg   <= {16'd0, idx2_reg} * {14'd0, span2_reg};

            rx4_reg  <= rx3_reg;
            ry4_reg  <= ry3_reg;
            st4_reg  <= st3_reg;
            idx4_reg <= idx3_reg;
            ip4_reg  <= ip3_reg;
            x4_reg   <= prod3_reg[27:8];
            q04_reg  <= recip_prod[34:20];

            num_reg  <= {ip4_reg, 8'd0};
            den_reg  <= (steps > 15'd1) ? steps[13:0] - 14'd1 : 14'd1;
            meta_reg <= meta_next;
        end
    end

    assign out_valid = v_reg[4];
    assign num       = num_reg;
    assign den       = den_reg;
    assign meta      = meta_reg;

endmodule

FILE: src/eapg_div.sv
module eapg_div
    import eapg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pipe_en,
    input  logic                  in_valid,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    input  meta_t                 meta_in,
    output logic                  out_valid,
    output logic [DIV_Q_BITS-1:0] quot,
    output meta_t                 meta_out
);

    logic [DEN_W-1:0]      rem_reg  [DIV_Q_BITS];
    logic [DIV_Q_BITS-1:0] work_reg [DIV_Q_BITS];
    logic [DEN_W-1:0]      den_reg  [DIV_Q_BITS];
    meta_t                 meta_reg [DIV_Q_BITS];
    logic [DIV_Q_BITS-1:0] v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= {v_reg[DIV_Q_BITS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < DIV_Q_BITS; k++) begin : g_stage
        logic [DEN_W-1:0]      rem_in, den_in;
        logic [DIV_Q_BITS-1:0] work_in;
        meta_t                 meta_in_k;
        logic [DEN_W:0]        trial;
        logic                  fits;

        if (k == 0) begin : g_first
            assign rem_in    = num[NUM_W-1:DIV_Q_BITS];
            assign work_in   = num[DIV_Q_BITS-1:0];
            assign den_in    = den;
            assign meta_in_k = meta_in;
        end else begin : g_next
            assign rem_in    = rem_reg[k-1];
            assign work_in   = work_reg[k-1];
            assign den_in    = den_reg[k-1];
            assign meta_in_k = meta_reg[k-1];
        end

        assign trial = {rem_in, work_in[DIV_Q_BITS-1]};
        assign fits  = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                rem_reg[k]  <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                work_reg[k] <= {work_in[DIV_Q_BITS-2:0], fits};
                den_reg[k]  <= den_in;
                meta_reg[k] <= meta_in_k;
            end
        end
    end

    assign out_valid = v_reg[DIV_Q_BITS-1];
    assign quot      = work_reg[DIV_Q_BITS-1];
    assign meta_out  = meta_reg[DIV_Q_BITS-1];

endmodule

FILE: src/eapg_cordic.sv
module eapg_cordic
    import eapg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     pipe_en,
    input  logic                     in_valid,
    input  logic [DIV_Q_BITS-1:0]    offset,
    input  meta_t                    meta_in,
    output logic                     out_valid,
    output logic signed [TRIG_W-1:0] cos_q30,
    output logic signed [TRIG_W-1:0] sin_q30,
    output meta_t                    meta_out
);

    localparam int N = CORDIC_STAGES;

    logic [N+1:0] v_reg;

    logic [23:0] ang_reg;
    meta_t       meta_a_reg;

    logic signed [TRIG_W-1:0] x_reg [N+1];
    logic signed [TRIG_W-1:0] y_reg [N+1];
    logic signed [Z_W-1:0]    z_reg [N+1];
    meta_t                    meta_reg [N+1];

    logic [24:0] ang_sum;
    logic [23:0] ang_w, z0;
    logic [1:0]  quad;
    meta_t       meta0_next;

    assign ang_sum = {1'b0, meta_in.st, 8'd0}
                   + ((meta_in.steps > 15'd1) ? {1'b0, offset} : 25'd0);
    assign ang_w   = (ang_sum >= {1'b0, FINE_TURN}) ? 24'(ang_sum - {1'b0, FINE_TURN})
                                                    : ang_sum[23:0];

    always_comb begin
        if (ang_reg >= 24'(FINE_QUARTER * 3)) begin
            quad = 2'd3;
            z0   = ang_reg - 24'(FINE_QUARTER * 3);
        end else if (ang_reg >= 24'(FINE_QUARTER * 2)) begin
            quad = 2'd2;
            z0   = ang_reg - 24'(FINE_QUARTER * 2);
        end else if (ang_reg >= FINE_QUARTER) begin
            quad = 2'd1;
            z0   = ang_reg - FINE_QUARTER;
        end else begin
            quad = 2'd0;
            z0   = ang_reg;
        end
    end

    always_comb begin
        meta0_next      = meta_a_reg;
        meta0_next.quad = quad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= {v_reg[N:0], in_valid};
        end
        if (pipe_en) begin
            ang_reg     <= ang_w;
            meta_a_reg  <= meta_in;
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({1'b0, z0});
            meta_reg[0] <= meta0_next;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [TRIG_W-1:0] xs, ys;
        logic signed [Z_W-1:0]    at;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = $signed({4'd0, ATAN_FINE[i]});

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                if (!z_reg[i][Z_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - at;
                end else begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                meta_reg[i+1] <= meta_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N+1];
    assign cos_q30   = x_reg[N];
    assign sin_q30   = y_reg[N];
    assign meta_out  = meta_reg[N];

endmodule

FILE: src/eapg_scale.sv
module eapg_scale
    import eapg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     pipe_en,
    input  logic                     in_valid,
    input  logic signed [TRIG_W-1:0] cos_q30,
    input  logic signed [TRIG_W-1:0] sin_q30,
    input  meta_t                    meta_in,
    output logic                     out_valid,
    output logic signed [16:0]       point_x,
    output logic signed [16:0]       point_y,
    output logic [14:0]              point_count,
    output logic                     point_valid,
    output logic                     last_point
);

    localparam int P_W = TRIG_W + 17;

    logic [2:0] v_reg;

    logic signed [TRIG_W-1:0] sn_reg, ny_reg;
    meta_t                    meta1_reg, meta2_reg;
    logic signed [P_W-1:0]    px_reg, py_reg;

    logic signed [16:0] x_reg, y_reg;
    logic [14:0]        cnt_reg;
    logic               pv_reg, last_reg;

    logic signed [TRIG_W-1:0] sn, ny;

    always_comb begin
        case (meta_in.quad)
            2'd0: begin
                sn = sin_q30;
                ny = -cos_q30;
            end
            2'd1: begin
                sn = cos_q30;
                ny = sin_q30;
            end
            2'd2: begin
                sn = -sin_q30;
                ny = cos_q30;
            end
            default: begin
                sn = -cos_q30;
                ny = -sin_q30;
            end
        endcase
    end

    function automatic logic signed [16:0] round_sat(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] t;
        logic signed [19:0]    r;
        t = p + (P_W'(1) <<< 29);
        r = 20'(t >>> 30);
        if (r > COORD_MAX) begin
            r = COORD_MAX;
        end else if (r < -COORD_MAX) begin
            r = -COORD_MAX;
        end
        return r[16:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
        if (pipe_en) begin
            sn_reg    <= sn;
            ny_reg    <= ny;
            meta1_reg <= meta_in;

            px_reg    <= P_W'(sn_reg) * $signed({{(P_W-16){1'b0}}, meta1_reg.rx});
            py_reg    <= P_W'(ny_reg) * $signed({{(P_W-16){1'b0}}, meta1_reg.ry});
            meta2_reg <= meta1_reg;

            x_reg    <= meta2_reg.valid ? round_sat(px_reg) : 17'sd0;
            y_reg    <= meta2_reg.valid ? round_sat(py_reg) : 17'sd0;
            cnt_reg  <= meta2_reg.steps;
            pv_reg   <= meta2_reg.valid;
            last_reg <= meta2_reg.last;
        end
    end

    assign out_valid   = v_reg[2];
    assign point_x     = x_reg;
    assign point_y     = y_reg;
    assign point_count = cnt_reg;
    assign point_valid = pv_reg;
    assign last_point  = last_reg;

endmodule

FILE: src/ellipse_arc_point_generator.sv
// elliptical arc point generator
// input channel s_*: one request per accepted beat carries both radii (q12.4),
// start and end angle (1/128 degree) and the point index
// output channel m_*: one result per request, in request order, with the
// point (signed q12.4), the arc's point count, a valid flag in tuser and
// tlast marking the final point of the arc
// requests pass in order through the point count, the pipelined angle
// divider (one quotient bit per stage), angle assembly, the CORDIC_STAGES
// (18) cordic stages and scaling
// throughput is one request per cycle while m_tready does not stall the
// pipeline; every stage is a register with its own valid bit
// reset clears all valid bits, so no results appear until new requests
// while the receiver holds m_tready low with a result pending, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated
module ellipse_arc_point_generator
    import eapg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // radius_horizontal, radius_vertical, arc_start, arc_end, point_index
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // point_x, point_y, point_count
    output logic [55:0] m_tdata,
    // point_valid
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic pipe_en;

    logic             st_valid;
    logic [NUM_W-1:0] st_num;
    logic [DEN_W-1:0] st_den;
    meta_t            st_meta;

    logic                  dv_valid;
    logic [DIV_Q_BITS-1:0] dv_quot;
    meta_t                 dv_meta;

    logic                     cr_valid;
    logic signed [TRIG_W-1:0] cr_cos, cr_sin;
    meta_t                    cr_meta;

    logic signed [16:0] point_x, point_y;
    logic [14:0]        point_count;
    logic               point_valid;

    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    eapg_steps u_steps (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (s_tvalid),
        .rx        (s_tdata[15:0]),
        .ry        (s_tdata[31:16]),
        .arc_start (s_tdata[47:32]),
        .arc_end   (s_tdata[63:48]),
        .idx       (s_tdata[77:64]),
        .out_valid (st_valid),
        .num       (st_num),
        .den       (st_den),
        .meta      (st_meta)
    );

    eapg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (st_valid),
        .num       (st_num),
        .den       (st_den),
        .meta_in   (st_meta),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .meta_out  (dv_meta)
    );

    eapg_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (dv_valid),
        .offset    (dv_quot),
        .meta_in   (dv_meta),
        .out_valid (cr_valid),
        .cos_q30   (cr_cos),
        .sin_q30   (cr_sin),
        .meta_out  (cr_meta)
    );

    eapg_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pipe_en     (pipe_en),
        .in_valid    (cr_valid),
        .cos_q30     (cr_cos),
        .sin_q30     (cr_sin),
        .meta_in     (cr_meta),
        .out_valid   (m_tvalid),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_count (point_count),
        .point_valid (point_valid),
        .last_point  (m_tlast)
    );

    assign m_tdata = {7'd0, point_count, point_y, point_x};
    assign m_tuser = point_valid;

endmodule
